@@ rtl/falts_pkg.sv @@
`timescale 1ns / 1ps

package falts_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic match;    // latch the compare results
    logic update;   // commit the store update and present the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register is empty or being drained this cycle
  } sts_t;

endpackage

@@ rtl/falts_ctrl.sv @@
`timescale 1ns / 1ps

module falts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  falts_pkg::sts_t   sts_i,
  output falts_pkg::cmd_t   cmd_o
);

  falts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= falts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      falts_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = falts_pkg::ST_MATCH;
      end
      falts_pkg::ST_MATCH: begin
        state_d = falts_pkg::ST_UPDATE;
      end
      falts_pkg::ST_UPDATE: begin
        if (sts_i.out_free) state_d = falts_pkg::ST_IDLE;
      end
      default: begin
        state_d = falts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      falts_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      falts_pkg::ST_MATCH: begin
        cmd_o.match = 1'b1;
      end
      falts_pkg::ST_UPDATE: begin
        cmd_o.update = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/falts_dp.sv @@
`timescale 1ns / 1ps

module falts_dp #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  falts_pkg::cmd_t                     cmd_i,
  output falts_pkg::sts_t                     sts_o,
  input  logic                                cfg_we_i,
  input  logic [falts_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic                                operation_i,
  input  logic [falts_pkg::ADDR_W-1:0]        address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [falts_pkg::COUNT_W-1:0]       hit_total_o,
  output logic [falts_pkg::COUNT_W-1:0]       miss_total_o
);

  localparam int unsigned TAG_W  = (ADDR_BITS < falts_pkg::ADDR_W) ? ADDR_BITS
                                                                    : falts_pkg::ADDR_W;
  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > falts_pkg::CAP_W) ? OCC_W : falts_pkg::CAP_W;

  // transaction registers
  logic             op_q;
  logic [TAG_W-1:0] addr_q;

  // per-entry state
  logic [TAG_W-1:0]  tag_q  [ENTRIES];
  logic [RANK_W-1:0] rank_q [ENTRIES];
  logic [RANK_W-1:0] rank_d [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] tag_we;

  // compare results
  logic [ENTRIES-1:0] match_q, victim_q, free_q;
  logic [ENTRIES-1:0] match_c, victim_c, free_c, invalid;

  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [RANK_W-1:0] occ_last;

  logic [falts_pkg::CAP_W-1:0]   cap_q;
  logic [falts_pkg::COUNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [falts_pkg::COUNT_W-1:0] miss_cnt_q, miss_cnt_d;

  logic out_valid_q, out_hit_q;

  logic [CMP_W-1:0]   cap_ext, eff_cap;
  logic               found, evict;
  logic [RANK_W-1:0]  hit_rank;
  logic [ENTRIES-1:0] slot;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // rank held by the least recent valid entry
  assign occ_last = RANK_W'(occ_q - OCC_W'(1));
  assign invalid  = ~valid_q;
  assign free_c   = invalid & (~invalid + ENTRIES'(1));

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cmp
    assign match_c[g]  = valid_q[g] && (tag_q[g] == addr_q);
    assign victim_c[g] = valid_q[g] && (rank_q[g] == occ_last);
  end

  // effective capacity: zero acts as one, clipped to the store size
  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign found = |match_q;
  assign evict = (CMP_W'(occ_q) >= eff_cap);
  assign slot  = evict ? victim_q : free_q;

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (rank_q[i] & {RANK_W{match_q[i]}});
    end
  end

  always_comb begin
    valid_d    = valid_q;
    tag_we     = '0;
    occ_d      = occ_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (found) begin
      // refresh recency of the hit entry
      for (int i = 0; i < ENTRIES; i++) begin
        if (match_q[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
    end else if (op_q == falts_pkg::OP_INSERT && (|slot)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot[i]) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
          tag_we[i]  = 1'b1;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
      if (!evict) occ_d = occ_q + OCC_W'(1);
    end
    if (op_q == falts_pkg::OP_LOOKUP) begin
      if (found) begin
        if (hit_cnt_q != falts_pkg::COUNT_MAX) begin
          hit_cnt_d = hit_cnt_q + falts_pkg::COUNT_W'(1);
        end
      end else begin
        if (miss_cnt_q != falts_pkg::COUNT_MAX) begin
          miss_cnt_d = miss_cnt_q + falts_pkg::COUNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      addr_q <= address_i[TAG_W-1:0];
    end
    if (cmd_i.match) begin
      match_q  <= match_c;
      victim_q <= victim_c;
      free_q   <= free_c;
    end
    if (cmd_i.update) begin
      out_hit_q <= found;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.update && tag_we[i]) tag_q[i] <= addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      cap_q       <= falts_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.update) begin
        valid_q    <= valid_d;
        occ_q      <= occ_d;
        hit_cnt_q  <= hit_cnt_d;
        miss_cnt_q <= miss_cnt_d;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // counters only move together with a new result, so they drive the port directly
  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

endmodule

@@ rtl/fully_assoc_lru_tag_store_top.sv @@
`timescale 1ns / 1ps

// Fully associative tag store of line addresses with true LRU replacement.
// Input channel (in_valid_i / in_stall_o): one transaction carries an
// operation (lookup or insert) and a line address. Output channel
// (out_valid_o / out_stall_i): exactly one result per input transaction,
// carrying the hit flag and the saturating lookup hit and miss totals.
// A transaction moves at a clock edge where valid is high and stall is low.
// An accepted input passes the tag compare, then the store update into
// the result register. A new transaction is accepted only after the
// previous one has finished the compare and update steps of the
// controller; the tags are compared in parallel.
// The capacity register (cfg_we_i / cfg_wdata_i) sets how many entries
// are used before eviction; write it only while the block is idle.
// Reset clears all valid bits, recency ranks, occupancy and both counters,
// and sets capacity to 16. No clearing pass is needed.
// When the receiver stalls, the result holds in the output register; the
// next transaction is taken and compared, but its update waits until the
// pending result has been drained.
module fully_assoc_lru_tag_store_top #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [falts_pkg::CAP_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [falts_pkg::ADDR_W-1:0]  address_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [falts_pkg::COUNT_W-1:0] hit_total_o,
  output logic [falts_pkg::COUNT_W-1:0] miss_total_o
);

  falts_pkg::cmd_t cmd;
  falts_pkg::sts_t sts;

  // sequencing: idle -> compare -> update
  falts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tag cells, recency ranks, occupancy, counters and result register
  falts_dp #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// LRU tag store check: a directed table, then random lookups and inserts under
// several capacity settings. Every transaction is run through the local LRU
// predictor, and each result is checked against the oldest queued expectation.
module testbench;
  import falts_pkg::*;

  localparam int unsigned NUM_ENTRIES  = 16;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned SEG_ITEMS    = 200;
  localparam int unsigned NUM_SEGS     = 8;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
  } result_t;

  // one line of the directed table; 'known' rows carry a hand-typed result
  typedef struct packed {
    bit                known;
    logic              op;
    logic [ADDR_W-1:0] addr;
    result_t           exp;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              operation_i = OP_LOOKUP;
  logic [ADDR_W-1:0] address_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              hit_o;
  logic [COUNT_W-1:0] hit_total_o;
  logic [COUNT_W-1:0] miss_total_o;

  // side-band for the directed rows, driven along with the payload
  bit      row_known = 1'b0;
  result_t row_exp   = '0;

  // idle rates in percent of cycles, changed per phase by the main sequence
  int unsigned send_idle_pct  = 36;
  int unsigned stall_idle_pct = 86;

  bit failed = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor state: tags, valid bits, recency ranks (0 = most recent)
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  lru_tag   [NUM_ENTRIES];
  bit                 lru_valid [NUM_ENTRIES];
  int unsigned        lru_rank  [NUM_ENTRIES];
  int unsigned        lru_occupancy;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] miss_count;
  logic [CAP_W-1:0]   capacity_reg;

  result_t  pending_results[$];
  dir_row_t dir_rows[$];

  fully_assoc_lru_tag_store_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // LRU predictor: one call per accepted transaction, returns its result
  // and advances the model state.
  // ---------------------------------------------------------------------------
  function automatic result_t lru_access(input logic op, input logic [ADDR_W-1:0] addr);
    int          found_slot;
    int          slot;
    int unsigned worst;
    int unsigned eff_cap;
    int unsigned old_rank;
    result_t     res;
    found_slot = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (found_slot < 0 && lru_valid[i] && lru_tag[i] == addr) found_slot = i;
    end

    // a hit promotes the entry; only younger entries age
    if (found_slot >= 0) begin
      old_rank = lru_rank[found_slot];
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (lru_valid[i] && i != found_slot && lru_rank[i] < old_rank) lru_rank[i]++;
      end
      lru_rank[found_slot] = 0;
    end

    if (op == OP_LOOKUP) begin
      if (found_slot >= 0) begin
        if (hit_count != COUNT_MAX) hit_count++;
      end else begin
        if (miss_count != COUNT_MAX) miss_count++;
      end
    end else if (found_slot < 0) begin
      // capacity 0 acts as 1, anything above the array size as the array size
      eff_cap = (capacity_reg == 0) ? 1 :
                (capacity_reg > NUM_ENTRIES) ? NUM_ENTRIES : capacity_reg;
      slot  = -1;
      worst = 0;
      // at or over capacity: drop exactly one LRU entry, never more
      if (lru_occupancy >= eff_cap) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (lru_valid[i] && (slot < 0 || lru_rank[i] > worst)) begin
            worst = lru_rank[i];
            slot  = i;
          end
        end
        if (slot >= 0) begin
          lru_valid[slot] = 1'b0;
          lru_occupancy--;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (slot < 0 && !lru_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (lru_valid[i]) lru_rank[i]++;
        end
        lru_tag[slot]   = addr;
        lru_valid[slot] = 1'b1;
        lru_rank[slot]  = 0;
        lru_occupancy++;
      end
    end

    res.hit        = (found_slot >= 0);
    res.hit_total  = hit_count;
    res.miss_total = miss_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: outputs are popped before inputs are pushed, so a result can
  // never be matched against the transaction accepted at the same edge.
  // All signals are read at the edge, i.e. their values from before it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, hit %0b hit_total %0d miss_total %0d",
                   $time, hit_o, hit_total_o, miss_total_o);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (hit_o !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, hit_o);
            failed = 1'b1;
          end
          if (hit_total_o !== want.hit_total) begin
            $display("%0t: hit_total mismatch, expected %0d, actual %0d",
                     $time, want.hit_total, hit_total_o);
            failed = 1'b1;
          end
          if (miss_total_o !== want.miss_total) begin
            $display("%0t: miss_total mismatch, expected %0d, actual %0d",
                     $time, want.miss_total, miss_total_o);
            failed = 1'b1;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        // predictor always runs so its state stays in step with the DUT
        pred = lru_access(operation_i, address_i);
        pending_results.push_back(row_known ? row_exp : pred);
      end
    end
  end

  // receiver back-pressure, a fresh coin per cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_idle_pct);
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("fully_assoc_lru_tag_store_top regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge where the transaction
  // was taken. Random idle cycles go in front of each transaction.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                           input bit known, input result_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    address_i   <= addr;
    row_known   <= known;
    row_exp     <= exp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // one edge first, so the scoreboard has queued the last accepted transaction
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // the sender holds off until every result is back, then writes capacity
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic add_row(input logic op, input logic [ADDR_W-1:0] addr, input bit known,
                         input logic h, input int unsigned ht, input int unsigned mt);
    dir_row_t row;
    row.known          = known;
    row.op             = op;
    row.addr           = addr;
    row.exp.hit        = h;
    row.exp.hit_total  = ht;
    row.exp.miss_total = mt;
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [CAP_W-1:0]  cap_plan  [NUM_SEGS];
    logic [63:0]       wide;
    logic [ADDR_W-1:0] addr;
    logic              op;
    int unsigned       pick;
    dir_row_t          row;

    // predictor matches the post-reset state of the block
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      lru_tag[i]   = '0;
      lru_valid[i] = 1'b0;
      lru_rank[i]  = 0;
    end
    lru_occupancy = 0;
    hit_count     = '0;
    miss_count    = '0;
    capacity_reg  = CAP_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. Rows with typed results are plain to read: empty store,
    // the two extreme addresses, a refresh by insert. The fill rows push the
    // store to 16 entries; the next insert evicts the all-ones line, which was
    // refreshed earlier than the zero line and so is least recent.
    add_row(OP_LOOKUP, 48'h0,              1'b1, 1'b0, 0, 1);
    add_row(OP_INSERT, 48'h0,              1'b1, 1'b0, 0, 1);
    add_row(OP_LOOKUP, 48'h0,              1'b1, 1'b1, 1, 1);
    add_row(OP_INSERT, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1, 1);
    add_row(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 2, 1);
    add_row(OP_INSERT, 48'h0,              1'b1, 1'b1, 2, 1);
    add_row(OP_LOOKUP, 48'h7FFF_FFFF_FFFF, 1'b1, 1'b0, 2, 2);
    add_row(OP_LOOKUP, 48'h8000_0000_0000, 1'b1, 1'b0, 2, 3);
    for (int k = 0; k < 14; k++) add_row(OP_INSERT, 48'h1 << (3 * k), 1'b0, 1'b0, 0, 0);
    add_row(OP_INSERT, 48'h8000_0000_0000, 1'b0, 1'b0, 0, 0);
    add_row(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 0, 0);
    add_row(OP_LOOKUP, 48'h1,              1'b0, 1'b0, 0, 0);

    while (dir_rows.size() != 0) begin
      row = dir_rows.pop_front();
      send_item(row.op, row.addr, row.known, row.exp);
    end

    // Random part. A small pool keeps hits and evictions frequent; near-pool
    // addresses differ in one bit, the rest are fully random. The first
    // setting drops capacity under the current occupancy of 16.
    for (int i = 0; i < POOL_SIZE; i++) begin
      wide = {$urandom(), $urandom()};
      addr_pool[i] = wide[ADDR_W-1:0];
    end
    cap_plan = '{5'd3, 5'd0, 5'd1, 5'd31, 5'd16, 5'd7, 5'd0, 5'd2};
    cap_plan[6] = CAP_W'($urandom_range(31));

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      // slow sender / busy receiver, then swapped, then full rate
      if (seg < 3) begin
        send_idle_pct  = 36;
        stall_idle_pct = 86;
      end else if (seg < 6) begin
        send_idle_pct  = 86;
        stall_idle_pct = 36;
      end else begin
        send_idle_pct  = 0;
        stall_idle_pct = 0;
      end
      write_capacity(cap_plan[seg]);
      for (int i = 0; i < 4; i++) begin
        wide = {$urandom(), $urandom()};
        addr_pool[$urandom_range(POOL_SIZE - 1)] = wide[ADDR_W-1:0];
      end
      repeat (SEG_ITEMS) begin
        op   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        wide = {$urandom(), $urandom()};
        if (pick < 70)
          addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 85)
          addr = addr_pool[$urandom_range(POOL_SIZE - 1)] ^ (48'h1 << $urandom_range(47));
        else
          addr = wide[ADDR_W-1:0];
        send_item(op, addr, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("fully_assoc_lru_tag_store_top regression: pass");
    end else begin
      $display("fully_assoc_lru_tag_store_top regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/falts_pkg.sv
rtl/falts_ctrl.sv
rtl/falts_dp.sv
rtl/fully_assoc_lru_tag_store_top.sv
test/testbench.sv
